/* design/sample_mean_and_std_macros.svh */
// Assertion macros for the sample statistics block.
`ifndef SAMPLE_MEAN_AND_STD_MACROS_SVH
`define SAMPLE_MEAN_AND_STD_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define SMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication.
`define SMS_ASSERT_IMP(lbl, ante, cons, msg) \
  `SMS_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define SMS_ASSERT_NXT(lbl, ante, cons, msg) \
  `SMS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* design/sms_pkg.sv */
package sms_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned SUM_W      = 33;
  localparam int unsigned SQSUM_W    = 47;
  localparam int unsigned RES_W      = 24;
  localparam int unsigned DIV_NUM_W  = 63;
  localparam int unsigned SQRT_IN_W  = 48;
  localparam int unsigned SQRT_REM_W = 26;
  localparam int unsigned STEP_W     = 6;

  localparam int unsigned MAX_SAMPLES = 65536;

  localparam logic [STEP_W-1:0] DIV_M_LAST = STEP_W'(40 - 1);
  localparam logic [STEP_W-1:0] DIV_S_LAST = STEP_W'(DIV_NUM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST  = STEP_W'(SQRT_IN_W / 2 - 1);

  typedef enum logic [3:0] {
    ST_ACC,
    ST_LOAD_M,
    ST_DIV_M,
    ST_FIX_M,
    ST_DIV_S,
    ST_MUL,
    ST_SUB,
    ST_SQRT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic acc_en;
    logic load_mean;
    logic div_step;
    logic fix_mean;
    logic mul;
    logic sub;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

/* design/sample_mean_and_std.sv */
// Population mean and standard deviation of a set of signed 16-bit samples.
// Input channel: sample_i / last_i with in_valid_i, in_stall_o. A request is
// taken on a rising edge with valid high and stall low. last_i closes a set.
// Output channel: mean_q8_o, std_q8_o (both 8 fraction bits), sample_count_o
// and overflow_flag_o with out_valid_o, out_stall_i; one result per set.
// Throughput: one sample per cycle while a set is open. The closing request
// stalls the input while a bit-serial divider makes 40 mean bits
// and 63 mean-square bits, one multiply and subtract, then a 24-step root.
// The result is registered after the root, once the output register is free.
// Samples beyond 65536 in a set are dropped and reported in overflow_flag_o.
// A waiting result does not hold up the next set; only if a second set
// finishes while the first result is still stalled does the block wait, with
// in_stall_o high, until the output register is free.
// Reset clears the accumulators and output valid; the block then takes samples.
module sample_mean_and_std
  import sms_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [RES_W-1:0]    mean_q8_o,
  output logic [RES_W-1:0]           std_q8_o,
  output logic [CNT_W-1:0]           sample_count_o,
  output logic                       overflow_flag_o
);

  cmd_t cmd;
  sts_t sts;

  sms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  sms_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mean_q8_o       (mean_q8_o),
    .std_q8_o        (std_q8_o),
    .sample_count_o  (sample_count_o),
    .overflow_flag_o (overflow_flag_o)
  );

endmodule

/* design/sms_ctrl.sv */
module sms_ctrl
  import sms_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic last_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_ACC: begin
        cmd_o.acc_en = in_valid_i;
        if (in_valid_i && last_i) begin
          state_d = ST_LOAD_M;
        end
      end
      ST_LOAD_M: begin
        cmd_o.load_mean = 1'b1;
        step_d          = DIV_M_LAST;
        state_d         = ST_DIV_M;
      end
      ST_DIV_M: begin
        cmd_o.div_step = 1'b1;
        if (step_q == '0) begin
          state_d = ST_FIX_M;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_FIX_M: begin
        cmd_o.fix_mean = 1'b1;
        step_d         = DIV_S_LAST;
        state_d        = ST_DIV_S;
      end
      ST_DIV_S: begin
        cmd_o.div_step = 1'b1;
        if (step_q == '0) begin
          state_d = ST_MUL;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUB;
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
        step_d    = SQRT_LAST;
        state_d   = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (step_q == '0) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_ACC);

endmodule

/* design/sms_datapath.sv */
module sms_datapath
  import sms_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [RES_W-1:0]    mean_q8_o,
  output logic [RES_W-1:0]           std_q8_o,
  output logic [CNT_W-1:0]           sample_count_o,
  output logic                       overflow_flag_o
);

  // accumulators
  logic signed [SUM_W-1:0]   sum_q;
  logic [SQSUM_W-1:0]        sqsum_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      drop_q;
  logic signed [2*SAMPLE_W-1:0] square;
  logic                      room;

  assign square = sample_i * sample_i;
  assign room   = (cnt_q < CNT_W'(MAX_SAMPLES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sqsum_q <= '0;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.out_load) begin
      sum_q   <= '0;
      sqsum_q <= '0;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (room) begin
        sum_q   <= sum_q + SUM_W'(sample_i);
        sqsum_q <= sqsum_q + SQSUM_W'($unsigned(square));
        cnt_q   <= cnt_q + 1'b1;
      end else begin
        drop_q  <= 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle; quotient shifts in at the bottom
  logic [DIV_NUM_W-1:0] num_q;
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       trial_diff;
  logic                 div_ge;
  logic                 neg_q;
  logic [SUM_W-1:0]     sum_neg;
  logic [SUM_W-2:0]     sum_mag;

  assign trial      = {rem_q, num_q[DIV_NUM_W-1]};
  assign div_ge     = (trial >= {1'b0, cnt_q});
  assign trial_diff = trial - {1'b0, cnt_q};
  assign sum_neg    = -sum_q;
  assign sum_mag    = sum_q[SUM_W-1] ? sum_neg[SUM_W-2:0] : sum_q[SUM_W-2:0];

  // floored signed mean from magnitude quotient and remainder
  logic [RES_W:0]       mean_mag;
  logic [RES_W:0]       mean_fix;
  assign mean_mag = {1'b0, num_q[RES_W-1:0]} + (RES_W+1)'(rem_q != '0);
  assign mean_fix = neg_q ? (RES_W+1)'(-mean_mag) : {1'b0, num_q[RES_W-1:0]};

  logic signed [RES_W-1:0]   mean_q;
  logic [SQSUM_W-1:0]        msq_q;
  logic [SQSUM_W-1:0]        quo_q;
  logic signed [2*RES_W-1:0] mean_sq;
  logic [SQSUM_W:0]          var_full;

  assign mean_sq  = mean_q * mean_q;
  assign var_full = {1'b0, quo_q} - {1'b0, msq_q};

  // integer square root, two radicand bits per cycle
  logic [SQRT_IN_W-1:0]    rad_q;
  logic [SQRT_REM_W-1:0]   srem_q;
  logic [RES_W-1:0]        root_q;
  logic [SQRT_REM_W+1:0]   srem_sh;
  logic [SQRT_REM_W+1:0]   strial;
  logic                    sqrt_ge;

  assign srem_sh = {srem_q, rad_q[SQRT_IN_W-1 -: 2]};
  assign strial  = {2'b00, root_q, 2'b01};
  assign sqrt_ge = (srem_sh >= strial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mean) begin
      num_q <= {sum_mag, 8'h00, (DIV_NUM_W - SUM_W + 1 - 8)'(0)};
      rem_q <= '0;
      neg_q <= sum_q[SUM_W-1];
    end else if (cmd_i.fix_mean) begin
      num_q  <= {sqsum_q, 16'h0000};
      rem_q  <= '0;
      mean_q <= mean_fix[RES_W-1:0];
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[DIV_NUM_W-2:0], div_ge};
      rem_q <= div_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
    if (cmd_i.mul) begin
      quo_q <= num_q[SQSUM_W-1:0];
      msq_q <= mean_sq[SQSUM_W-1:0];
    end
    if (cmd_i.sub) begin
      rad_q  <= var_full[SQSUM_W] ? '0 : {1'b0, var_full[SQSUM_W-1:0]};
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[SQRT_IN_W-3:0], 2'b00};
      srem_q <= sqrt_ge ? SQRT_REM_W'(srem_sh - strial) : srem_sh[SQRT_REM_W-1:0];
      root_q <= {root_q[RES_W-2:0], sqrt_ge};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mean_q8_o       <= mean_q;
      std_q8_o        <= root_q;
      sample_count_o  <= cnt_q;
      overflow_flag_o <= drop_q;
    end
  end

  assign sts_o.out_free = !out_valid_o || !out_stall_i;

endmodule

/* design/sms_checker.sv */
`include "sample_mean_and_std_macros.svh"

module sms_checker
  import sms_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic signed [SAMPLE_W-1:0] sample_i,
  input logic                       last_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic signed [RES_W-1:0]    mean_q8_o,
  input logic [RES_W-1:0]           std_q8_o,
  input logic [CNT_W-1:0]           sample_count_o,
  input logic                       overflow_flag_o
);

  `SMS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(mean_q8_o) && $stable(std_q8_o) && $stable(sample_count_o), "stalled result changed")
  `SMS_ASSERT_IMP(a_stall_on_last, $rose(in_stall_o), $past(in_valid_i && last_i), "input stalled without a closing request")
  `SMS_ASSERT_IMP(a_result_after_calc, $rose(out_valid_o), $past(in_stall_o), "result appeared outside a calculation")
  `SMS_ASSERT_IMP(a_result_range, out_valid_o, sample_count_o != '0 && std_q8_o <= 24'h800000, "result out of range")

endmodule

bind sample_mean_and_std sms_checker u_sms_checker (.*);

/* test/tb_sample_mean_and_std.sv */
`default_nettype none

module tb_sample_mean_and_std;
  timeunit 1ns;
  timeprecision 1ps;
  import sms_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 140;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef struct packed {
    logic signed [RES_W-1:0] mean_q8;
    logic [RES_W-1:0]        std_q8;
    logic [CNT_W-1:0]        sample_count;
    logic                    overflow_flag;
  } set_stats_t;

  typedef enum {MIX_WIDE, MIX_EDGE, MIX_FLAT, MIX_TINY} sample_mix_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       last_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [RES_W-1:0]    mean_q8_o;
  logic [RES_W-1:0]           std_q8_o;
  logic [CNT_W-1:0]           sample_count_o;
  logic                       overflow_flag_o;

  sample_mean_and_std dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mean_q8_o       (mean_q8_o),
    .std_q8_o        (std_q8_o),
    .sample_count_o  (sample_count_o),
    .overflow_flag_o (overflow_flag_o)
  );

  // running set state of the predictor
  longint      run_sum = 0;
  bit [63:0]   run_sq = '0;
  int unsigned run_n = 0;
  bit          run_drop = 1'b0;

  set_stats_t  stats_due[$];
  int          errors = 0;
  bit          calm;
  int unsigned quiet = 0;

  always begin
    clk_i = 1'b0;
    #5ns;
    clk_i = 1'b1;
    #5ns;
  end

  function automatic bit [63:0] floor_root(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void fold_sample(logic signed [SAMPLE_W-1:0] s, logic closing);
    longint     smp;
    longint     num;
    longint     mean;
    longint     variance;
    bit [63:0]  root;
    set_stats_t got;
    smp = longint'(s);
    if (run_n < MAX_SAMPLES) begin
      run_sum += smp;
      run_sq  += 64'(smp * smp);
      run_n++;
    end else begin
      run_drop = 1'b1;
    end
    if (!closing) return;
    mean = 0;
    root = '0;
    if (run_n != 0) begin
      num  = run_sum * 256;
      mean = num / longint'(run_n);
      if (num < 0 && (num % longint'(run_n)) != 0) mean = mean - 1;
      variance = longint'((run_sq << 16) / 64'(run_n)) - mean * mean;
      if (variance > 0) root = floor_root(64'(variance));
    end
    got.mean_q8       = mean[RES_W-1:0];
    got.std_q8        = root[RES_W-1:0];
    got.sample_count  = run_n[CNT_W-1:0];
    got.overflow_flag = run_drop;
    stats_due = {stats_due, got};
    run_sum  = 0;
    run_sq   = '0;
    run_n    = 0;
    run_drop = 1'b0;
  endfunction

  always @(posedge clk_i) begin : check_proc
    set_stats_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) fold_sample(sample_i, last_i);
      if (out_valid_o && !out_stall_i) begin
        if (stats_due.size() == 0) begin
          $display("%0t: unexpected result mean_q8 %0d std_q8 %0d count %0d overflow %0d",
                   $time, mean_q8_o, std_q8_o, sample_count_o, overflow_flag_o);
          errors++;
        end else begin
          want = stats_due.pop_front();
          if (want.mean_q8 !== mean_q8_o) begin
            $display("%0t: mean_q8 expected %0d got %0d", $time, want.mean_q8, mean_q8_o);
            errors++;
          end
          if (want.std_q8 !== std_q8_o) begin
            $display("%0t: std_q8 expected %0d got %0d", $time, want.std_q8, std_q8_o);
            errors++;
          end
          if (want.sample_count !== sample_count_o) begin
            $display("%0t: sample_count expected %0d got %0d", $time,
                     want.sample_count, sample_count_o);
            errors++;
          end
          if (want.overflow_flag !== overflow_flag_o) begin
            $display("%0t: overflow_flag expected %0d got %0d", $time,
                     want.overflow_flag, overflow_flag_o);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 17);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // one request, held until taken
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic closing);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= closing;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic test_single_sample_sets();
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd1, 1'b1);
  endtask

  task automatic test_small_sets();
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd2, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
  endtask

  // floored mean of the near-constant set at SAMPLE_MIN pushes the variance below zero
  task automatic test_negative_variance();
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN + 16'sd1, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX - 16'sd1, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(sample_mix_e mix,
                                                             logic signed [SAMPLE_W-1:0] base);
    case (mix)
      MIX_EDGE: begin
        return ($urandom_range(1) == 0) ? SAMPLE_MIN : SAMPLE_MAX;
      end
      MIX_FLAT: begin
        return (base == SAMPLE_MAX) ? base - SAMPLE_W'($urandom_range(1))
                                    : base + SAMPLE_W'($urandom_range(1));
      end
      MIX_TINY: begin
        return SAMPLE_W'(int'($urandom_range(16)) - 8);
      end
      default: begin
        return SAMPLE_W'($urandom);
      end
    endcase
  endfunction

  task automatic test_random_sets();
    int                         sent;
    int                         len;
    sample_mix_e                mix;
    logic signed [SAMPLE_W-1:0] base;
    sent = 0;
    while (sent < 650) begin
      calm = (sent >= 250 && sent < 400);
      len  = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      mix  = sample_mix_e'($urandom_range(3));
      base = SAMPLE_W'($urandom);
      for (int k = 0; k < len; k++) begin
        send_sample(pick_sample(mix, base), k == len - 1);
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    last_i      = 1'b0;
    calm        = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_sample_sets();
    test_small_sets();
    test_negative_variance();
    test_random_sets();

    in_valid_i <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && stats_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
